>>> hdl/rolling_trend_r_squared_top_defines.svh
// Assertion macros for the rolling trend r-squared block.
// Needs signals named clock and reset in the scope of each use.
`ifndef ROLLING_TREND_R_SQUARED_TOP_DEFINES_SVH
`define ROLLING_TREND_R_SQUARED_TOP_DEFINES_SVH

// same-cycle implication
`define RTSQ_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rtsq assertion failed");

// next-cycle implication
`define RTSQ_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rtsq assertion failed");

`endif

>>> hdl/rtsq_pkg.sv
// Package of the rolling trend r-squared block: widths, constants, types.
// No dependencies.
`timescale 1ns / 1ps

package rtsq_pkg;

   localparam int MAX_WINDOW = 64;
   localparam int IDX_W      = 6;
   localparam int CNT_W      = 7;
   localparam int SAMPLE_W   = 32;
   localparam int S_W        = 38;
   localparam int IV_W       = 39;
   localparam int X_W        = 44;
   localparam int VV_W       = 64;
   localparam int Q_W        = 69;
   localparam int A_W        = 46;
   localparam int B_W        = 75;
   localparam int K_W        = 12;
   localparam int PROD_W     = 90;
   localparam int MPL_W      = 46;
   localparam int DEN_W      = 87;
   localparam int NUM_W      = 108;
   localparam int QUO_W      = 17;
   localparam int QUO_MSB    = 16;

   localparam logic [CNT_W-1:0] WINDOW_RESET = 7'd14;
   localparam logic [CNT_W-1:0] WINDOW_MAX   = 7'd64;
   localparam logic [QUO_W-1:0] ONE_Q16      = 17'd65536;

   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] mcand;
      logic [MPL_W-1:0]  mplier;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] product;
   } mul_rsp_type;

endpackage

>>> hdl/rtsq_if.sv
// Channel interfaces of the rolling trend r-squared block.
// Depends on rtsq_pkg.
`timescale 1ns / 1ps

interface rtsq_req_if import rtsq_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_value;
   logic                       sample_present;
   modport source (output valid, sample_value, sample_present, input ready);
   modport sink (input valid, sample_value, sample_present, output ready);
endinterface

interface rtsq_rsp_if import rtsq_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [QUO_W-1:0] r_squared;
   logic             result_valid;
   logic             flat_window;
   modport source (output valid, r_squared, result_valid, flat_window, input ready);
   modport sink (input valid, r_squared, result_valid, flat_window, output ready);
endinterface

interface rtsq_csr_if import rtsq_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] window_length;
   modport source (output valid, window_length, input ready);
   modport sink (input valid, window_length, output ready);
endinterface

>>> hdl/rtsq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rtsq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/rtsq_mul.sv
// Shared shift-add multiplier, one multiplier bit a cycle, unsigned.
// Depends on rtsq_pkg.
`timescale 1ns / 1ps

module rtsq_mul import rtsq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mreq,
   output mul_rsp_type mrsp
);

   logic [PROD_W-1:0] acc_ff;
   logic [PROD_W-1:0] mc_ff;
   logic [MPL_W-1:0]  mp_ff;
   logic              busy_ff;
   logic              done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (mreq.start) begin
            acc_ff  <= '0;
            mc_ff   <= mreq.mcand;
            mp_ff   <= mreq.mplier;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (mp_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               if (mp_ff[0]) begin
                  acc_ff <= acc_ff + mc_ff;
               end
               mc_ff <= mc_ff << 1;
               mp_ff <= mp_ff >> 1;
            end
         end
      end
   end

   assign mrsp.done    = done_ff;
   assign mrsp.product = acc_ff;

endmodule

>>> hdl/rolling_trend_r_squared_top.sv
// Top level of the rolling trend r-squared block: ring, sequencer, divider.
// Depends on rtsq_pkg, rtsq_if, rtsq_ram and rtsq_mul.
//
//   channel   dir  beat
//   req_bus   in   sample_value, sample_present
//   rsp_bus   out  r_squared, result_valid, flat_window
//   csr_bus   in   window_length
//
// The time for one beat is set by the window walk through the ring RAM read port and
// the shift-add multiplier, then by the restoring division. A short window or partial
// fill skips the walk and goes straight to the output state.
// Reset is synchronous; the ring needs no clearing. req_bus.ready stays low from
// accept until the result is held in the output register.
`timescale 1ns / 1ps

module rolling_trend_r_squared_top import rtsq_pkg::*; (
   input logic        clock,
   input logic        reset,
   rtsq_req_if.sink   req_bus,
   rtsq_rsp_if.source rsp_bus,
   rtsq_csr_if.sink   csr_bus
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_LOAD, ST_DRAIN, ST_MUL_SS, ST_MUL_NQ,
      ST_CHK_B, ST_MUL_AA, ST_MUL_DEN, ST_DIV, ST_OUT
   } state_type;

   state_type                 state_ff;
   logic [CNT_W-1:0]          wl_ff;
   logic [IDX_W-1:0]          widx_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic [IDX_W-1:0]          slot_ff;
   logic [IDX_W-1:0]          iss_ff;
   logic                      v1_ff;
   logic [IDX_W-1:0]          i1_ff;
   logic                      v2_ff;
   logic signed [SAMPLE_W-1:0] vs_ff;
   logic signed [IV_W-1:0]    iv_ff;
   logic [VV_W-1:0]           vv_ff;
   logic signed [S_W-1:0]     s_ff;
   logic signed [X_W-1:0]     x_ff;
   logic [Q_W-1:0]            q_ff;
   logic [B_W-1:0]            ss_ff;
   logic [B_W-1:0]            b_ff;
   logic signed [A_W-1:0]     a_ff;
   logic [K_W-1:0]            k_ff;
   logic [NUM_W-1:0]          num_ff;
   logic [NUM_W-1:0]          td_ff;
   logic [QUO_W-1:0]          quo_ff;
   logic [4:0]                bit_ff;
   mul_req_type               mreq_ff;
   logic [QUO_W-1:0]          res_r_ff;
   logic                      res_v_ff;
   logic                      res_f_ff;
   logic                      rsp_valid_ff;
   logic [QUO_W-1:0]          rsp_r_ff;
   logic                      rsp_v_ff;
   logic                      rsp_f_ff;

   logic [CNT_W-1:0]          n_eff;
   logic [CNT_W-1:0]          n_m1;
   logic                      req_acc;
   logic [SAMPLE_W-1:0]       rd_data;
   mul_rsp_type               mrsp;
   logic [S_W-1:0]            s_mag;
   logic [A_W-1:0]            a_mag;
   logic signed [A_W-1:0]     x2;
   logic signed [A_W-1:0]     nm1s;
   logic [NUM_W-1:0]          num_sub;
   logic                      fits;
   logic [QUO_W-1:0]          quo_next;
   logic [NUM_W-1:0]          aa3;
   logic [2*CNT_W-1:0]        nn;
   logic                      mul_go;

   function automatic logic [IDX_W-1:0] slot_after(logic [IDX_W-1:0] s, logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] s1;
      s1 = {1'b0, s} + 1'b1;
      return (s1 >= n) ? '0 : s1[IDX_W-1:0];
   endfunction

   assign n_eff   = (wl_ff > WINDOW_MAX) ? WINDOW_MAX : wl_ff;
   assign n_m1    = n_eff - 1'b1;
   assign req_acc = req_bus.valid && req_bus.ready;
   assign s_mag   = s_ff[S_W-1] ? S_W'(-s_ff) : S_W'(s_ff);
   assign a_mag   = a_ff[A_W-1] ? A_W'(-a_ff) : A_W'(a_ff);
   assign x2      = {x_ff[X_W-1], x_ff, 1'b0};
   assign nm1s    = $signed({1'b0, n_m1}) * s_ff;
   assign num_sub = num_ff - td_ff;
   assign fits    = num_ff >= td_ff;
   assign aa3     = NUM_W'({mrsp.product, 1'b0}) + NUM_W'(mrsp.product);
   assign nn      = n_eff * n_eff;
   assign mul_go  = (state_ff == ST_DRAIN && !v1_ff && !v2_ff)
                 || ((state_ff == ST_MUL_SS || state_ff == ST_MUL_AA) && mrsp.done)
                 || (state_ff == ST_CHK_B && b_ff != '0);

   always_comb begin
      quo_next = quo_ff;
      if (fits) begin
         quo_next[bit_ff] = 1'b1;
      end
   end

   rtsq_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WINDOW)) u_ring (
      .clock (clock),
      .we    (req_acc && req_bus.sample_present),
      .waddr (widx_ff),
      .wdata (req_bus.sample_value),
      .raddr (slot_ff),
      .rdata (rd_data)
   );

   rtsq_mul u_mul (
      .clock (clock),
      .reset (reset),
      .mreq  (mreq_ff),
      .mrsp  (mrsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wl_ff         <= WINDOW_RESET;
         widx_ff       <= '0;
         cnt_ff        <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         mreq_ff.start <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mreq_ff.start <= mul_go;
         v1_ff         <= (state_ff == ST_LOAD);
         v2_ff         <= v1_ff;
         if (csr_bus.valid) begin
            wl_ff <= csr_bus.window_length;
         end
         if (rsp_valid_ff && rsp_bus.ready && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         // products of the window walk
         if (v1_ff) begin
            vs_ff <= $signed(rd_data);
            iv_ff <= $signed({1'b0, i1_ff}) * $signed(rd_data);
            vv_ff <= VV_W'($signed(rd_data)) * VV_W'($signed(rd_data));
         end
         if (v2_ff) begin
            s_ff <= s_ff + S_W'(vs_ff);
            x_ff <= x_ff + X_W'(iv_ff);
            q_ff <= q_ff + Q_W'(vv_ff);
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  if (req_bus.sample_present) begin
                     if (cnt_ff < WINDOW_MAX) begin
                        cnt_ff <= cnt_ff + 1'b1;
                     end
                     widx_ff <= slot_after(widx_ff, n_eff);
                  end
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               res_r_ff <= '0;
               res_f_ff <= 1'b0;
               res_v_ff <= 1'b0;
               s_ff     <= '0;
               x_ff     <= '0;
               q_ff     <= '0;
               iss_ff   <= '0;
               slot_ff  <= ({1'b0, widx_ff} < n_eff) ? widx_ff : '0;
               if (n_eff < 7'd2 || n_eff > cnt_ff) begin
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               i1_ff   <= iss_ff;
               slot_ff <= slot_after(slot_ff, n_eff);
               iss_ff  <= iss_ff + 1'b1;
               if ({1'b0, iss_ff} == n_m1) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!v1_ff && !v2_ff) begin
                  mreq_ff.mcand  <= PROD_W'(s_mag);
                  mreq_ff.mplier <= MPL_W'(s_mag);
                  state_ff       <= ST_MUL_SS;
               end
            end
            ST_MUL_SS: begin
               if (mrsp.done) begin
                  ss_ff          <= mrsp.product[B_W-1:0];
                  mreq_ff.mcand  <= PROD_W'(q_ff);
                  mreq_ff.mplier <= MPL_W'(n_eff);
                  state_ff       <= ST_MUL_NQ;
               end
            end
            ST_MUL_NQ: begin
               if (mrsp.done) begin
                  b_ff     <= mrsp.product[B_W-1:0] - ss_ff;
                  a_ff     <= x2 - nm1s;
                  state_ff <= ST_CHK_B;
               end
            end
            ST_CHK_B: begin
               res_v_ff <= 1'b1;
               k_ff     <= K_W'(nn - 1'b1);
               if (b_ff == '0) begin
                  res_f_ff <= 1'b1;
                  state_ff <= ST_OUT;
               end else begin
                  mreq_ff.mcand  <= PROD_W'(a_mag);
                  mreq_ff.mplier <= a_mag;
                  state_ff       <= ST_MUL_AA;
               end
            end
            ST_MUL_AA: begin
               if (mrsp.done) begin
                  num_ff         <= aa3 << 16;
                  mreq_ff.mcand  <= PROD_W'(b_ff);
                  mreq_ff.mplier <= MPL_W'(k_ff);
                  state_ff       <= ST_MUL_DEN;
               end
            end
            ST_MUL_DEN: begin
               if (mrsp.done) begin
                  td_ff    <= NUM_W'(mrsp.product[DEN_W-1:0]) << 16;
                  quo_ff   <= '0;
                  bit_ff   <= 5'd16;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (fits) begin
                  num_ff <= num_sub;
               end
               quo_ff <= quo_next;
               td_ff  <= td_ff >> 1;
               bit_ff <= bit_ff - 1'b1;
               if (bit_ff == '0) begin
                  res_r_ff <= (quo_next > ONE_Q16) ? ONE_Q16 : quo_next;
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_r_ff     <= res_r_ff;
                  rsp_v_ff     <= res_v_ff;
                  rsp_f_ff     <= res_f_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_bus.ready         = (state_ff == ST_IDLE);
   assign csr_bus.ready         = 1'b1;
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.r_squared     = rsp_r_ff;
   assign rsp_bus.result_valid  = rsp_v_ff;
   assign rsp_bus.flat_window   = rsp_f_ff;

endmodule

>>> hdl/rtsq_chk.sv
// Port checker for the rolling trend r-squared block, bound to the top level.
// Depends on rtsq_pkg and rolling_trend_r_squared_top_defines.svh.
`timescale 1ns / 1ps
`include "rolling_trend_r_squared_top_defines.svh"

module rtsq_chk import rtsq_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [QUO_W-1:0] rsp_r_squared,
   input logic             rsp_result_valid,
   input logic             rsp_flat_window
);

   `RTSQ_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_r_squared) && $stable(rsp_result_valid) && $stable(rsp_flat_window))
   `RTSQ_ASSERT_IMP(a_null_clean, rsp_valid && !rsp_result_valid, rsp_r_squared == '0 && !rsp_flat_window)
   `RTSQ_ASSERT_IMP(a_flat_zero, rsp_valid && rsp_flat_window, rsp_r_squared == '0 && rsp_result_valid)
   `RTSQ_ASSERT_NXT(a_busy_after_beat, req_valid && req_ready, !req_ready)

endmodule

bind rolling_trend_r_squared_top rtsq_chk u_rtsq_chk (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_r_squared    (rsp_bus.r_squared),
   .rsp_result_valid (rsp_bus.result_valid),
   .rsp_flat_window  (rsp_bus.flat_window)
);
